// ===== hw/rtl/cramer_linear_solve_assert.svh =====
// Assertion macros for the Cramer solver. Each expects clock and reset in scope.
`ifndef CRAMER_LINEAR_SOLVE_ASSERT_SVH
`define CRAMER_LINEAR_SOLVE_ASSERT_SVH
`ifndef SYNTHESIS
`define CRM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cramer_linear_solve: assertion failed");
`define CRM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cramer_linear_solve: assertion failed");
`else
`define CRM_ASSERT(lbl, prop)
`define CRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/cramer_pkg.sv =====
package cramer_pkg;

   // Field and datapath widths.
   localparam int WORD_W = 32;
   localparam int QUO_W = 32;
   localparam int THR_W = 31;
   localparam int SIZE_W = 2;
   localparam int CSR_IDX_W = 2;
   // A 3x3 determinant of 32-bit entries stays below 2^96 in magnitude.
   localparam int MAG_W = 96;
   localparam int DET_W = MAG_W + 1;
   localparam int DET_LAT = 5;
   localparam int DEF_FRAC_BITS = 16;

   // Queue between the front and the back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_TWO = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 2'd3;
   localparam logic [THR_W-1:0] THR_RESET = 31'd1;

   // Saturation limits of a quotient magnitude.
   localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic signed [WORD_W-1:0] coef_r0_c0;
      logic signed [WORD_W-1:0] coef_r0_c1;
      logic signed [WORD_W-1:0] coef_r0_c2;
      logic signed [WORD_W-1:0] coef_r1_c0;
      logic signed [WORD_W-1:0] coef_r1_c1;
      logic signed [WORD_W-1:0] coef_r1_c2;
      logic signed [WORD_W-1:0] coef_r2_c0;
      logic signed [WORD_W-1:0] coef_r2_c1;
      logic signed [WORD_W-1:0] coef_r2_c2;
      logic signed [WORD_W-1:0] rhs_first;
      logic signed [WORD_W-1:0] rhs_second;
      logic signed [WORD_W-1:0] rhs_third;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] sol_first;
      logic signed [WORD_W-1:0] sol_second;
      logic signed [WORD_W-1:0] sol_third;
      logic solved;
      logic saturated;
   } rsp_type;

   typedef logic [2:0][2:0][WORD_W-1:0] mat_type;

   // A classified system: always 3x3, a 2x2 system is embedded with a unit corner.
   typedef struct packed {
      mat_type mat;
      logic [2:0][WORD_W-1:0] rhs;
      logic [MAG_W-1:0] thr;
      logic is_two;
   } job_type;

endpackage

// ===== hw/rtl/cramer_front.sv =====
module cramer_front import cramer_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input logic clock,
   input logic reset,
   input logic req_take,
   input req_type req_word,
   input logic csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [THR_W-1:0] csr_wdata,
   output logic job_valid,
   output job_type job
);

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic job_valid_ff, job_valid_in;
   job_type job_ff, job_in;
   logic is_two;

   // Register writes; unknown indexes are dropped.
   always_comb begin
      thr_in = thr_ff;
      size_in = size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in = csr_wdata;
            CSR_SIZE: size_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Classify the word: a 2x2 system becomes a 3x3 one with a unit lower corner,
   // and the threshold moves to the scale of the determinant.
   always_comb begin
      is_two = (size_ff == SIZE_TWO);
      job_valid_in = req_take;
      job_in.mat[0][0] = req_word.coef_r0_c0;
      job_in.mat[0][1] = req_word.coef_r0_c1;
      job_in.mat[0][2] = req_word.coef_r0_c2;
      job_in.mat[1][0] = req_word.coef_r1_c0;
      job_in.mat[1][1] = req_word.coef_r1_c1;
      job_in.mat[1][2] = req_word.coef_r1_c2;
      job_in.mat[2][0] = req_word.coef_r2_c0;
      job_in.mat[2][1] = req_word.coef_r2_c1;
      job_in.mat[2][2] = req_word.coef_r2_c2;
      job_in.rhs[0] = req_word.rhs_first;
      job_in.rhs[1] = req_word.rhs_second;
      job_in.rhs[2] = req_word.rhs_third;
      job_in.is_two = is_two;
      if (is_two) begin
         job_in.mat[0][2] = '0;
         job_in.mat[1][2] = '0;
         job_in.mat[2][0] = '0;
         job_in.mat[2][1] = '0;
         job_in.mat[2][2] = WORD_W'(1);
         job_in.rhs[2] = '0;
         job_in.thr = MAG_W'(thr_ff) << FRAC_BITS;
      end else begin
         job_in.thr = MAG_W'(thr_ff) << (2 * FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         size_ff <= SIZE_RESET;
         job_valid_ff <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         size_ff <= size_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job = job_ff;

endmodule

// ===== hw/rtl/cramer_queue.sv =====
`include "cramer_linear_solve_assert.svh"
module cramer_queue import cramer_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input job_type push_job,
   input logic pop,
   output job_type head_job,
   output logic head_valid,
   output logic full
);

   job_type slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + Q_PTR_W'(pop);
      count_in = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full = (count_ff == Q_CNT_W'(Q_DEPTH));

   `CRM_ASSERT(a_no_overflow, (push && full) |-> pop)
   `CRM_ASSERT(a_no_underflow, pop |-> head_valid)
   `CRM_ASSERT_NEXT(a_fill_bound, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))

endmodule

// ===== hw/rtl/cramer_det.sv =====
module cramer_det import cramer_pkg::*; (
   input logic clock,
   input mat_type mat,
   output logic signed [DET_W-1:0] det
);

   logic signed [2*WORD_W-1:0] prod_ff [6], prod_in [6];
   logic [WORD_W-1:0] top1_ff [3], top2_ff [3];
   logic signed [2*WORD_W:0] minor_ff [3], minor_in [3];
   logic signed [2*WORD_W:0] lo_ff [3], lo_in [3];
   logic signed [2*WORD_W:0] hi_ff [3], hi_in [3];
   logic signed [DET_W-1:0] term_ff [3], term_in [3];
   logic signed [DET_W-1:0] det_ff, det_in;

   // Stage one: the six products of the lower 2x2 minors.
   always_comb begin
      prod_in[0] = $signed(mat[1][1]) * $signed(mat[2][2]);
      prod_in[1] = $signed(mat[2][1]) * $signed(mat[1][2]);
      prod_in[2] = $signed(mat[1][0]) * $signed(mat[2][2]);
      prod_in[3] = $signed(mat[2][0]) * $signed(mat[1][2]);
      prod_in[4] = $signed(mat[1][0]) * $signed(mat[2][1]);
      prod_in[5] = $signed(mat[2][0]) * $signed(mat[1][1]);
   end

   // Stage two: minors. Stage three: top row times minor, split into two halves.
   // Stage four: halves recombined. Stage five: the cofactor sum.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         minor_in[j] = (2*WORD_W+1)'(prod_ff[2*j]) - (2*WORD_W+1)'(prod_ff[2*j+1]);
         lo_in[j] = $signed(top2_ff[j]) * $signed({1'b0, minor_ff[j][WORD_W-1:0]});
         hi_in[j] = $signed(top2_ff[j]) * $signed(minor_ff[j][2*WORD_W:WORD_W]);
         term_in[j] = (DET_W'(hi_ff[j]) <<< WORD_W) + DET_W'(lo_ff[j]);
      end
      det_in = term_ff[0] - term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 6; j++) begin
         prod_ff[j] <= prod_in[j];
      end
      for (int j = 0; j < 3; j++) begin
         top1_ff[j] <= mat[0][j];
         top2_ff[j] <= top1_ff[j];
         minor_ff[j] <= minor_in[j];
         lo_ff[j] <= lo_in[j];
         hi_ff[j] <= hi_in[j];
         term_ff[j] <= term_in[j];
      end
      det_ff <= det_in;
   end

   assign det = det_ff;

endmodule

// ===== hw/rtl/cramer_div.sv =====
module cramer_div import cramer_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input logic clock,
   input logic [MAG_W-1:0] num_mag,
   input logic [MAG_W-1:0] den_mag,
   output logic [QUO_W-1:0] quo,
   output logic over
);

   localparam int NUM_W = MAG_W + FRAC_BITS;
   localparam int TOP_W = NUM_W - QUO_W;

   logic [NUM_W-1:0] num_sh;
   logic [TOP_W-1:0] num_top;
   logic [MAG_W-1:0] rem_ff [QUO_W+1];
   logic [QUO_W-1:0] low_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff [QUO_W+1];
   logic [MAG_W-1:0] den_ff [QUO_W+1];
   logic over_ff [QUO_W+1];
   logic [MAG_W:0] trial [QUO_W];
   logic [MAG_W:0] diff [QUO_W];
   logic take [QUO_W];

   // The scaled numerator; its upper part decides whether the quotient fits.
   always_comb begin
      num_sh = NUM_W'(num_mag) << FRAC_BITS;
      num_top = num_sh[NUM_W-1:QUO_W];
   end

   // One restoring step per stage, one quotient bit each.
   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         trial[s] = {rem_ff[s], low_ff[s][QUO_W-1]};
         diff[s] = trial[s] - {1'b0, den_ff[s]};
         take[s] = (trial[s] >= {1'b0, den_ff[s]});
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= MAG_W'(num_top);
      low_ff[0] <= num_sh[QUO_W-1:0];
      q_ff[0] <= '0;
      den_ff[0] <= den_mag;
      over_ff[0] <= (MAG_W'(num_top) >= den_mag);
      for (int s = 0; s < QUO_W; s++) begin
         rem_ff[s+1] <= take[s] ? diff[s][MAG_W-1:0] : trial[s][MAG_W-1:0];
         low_ff[s+1] <= {low_ff[s][QUO_W-2:0], 1'b0};
         q_ff[s+1] <= {q_ff[s][QUO_W-2:0], take[s]};
         den_ff[s+1] <= den_ff[s];
         over_ff[s+1] <= over_ff[s];
      end
   end

   assign quo = q_ff[QUO_W];
   assign over = over_ff[QUO_W];

endmodule

// ===== hw/rtl/cramer_back.sv =====
`include "cramer_linear_solve_assert.svh"
module cramer_back import cramer_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input logic clock,
   input logic reset,
   input logic job_valid,
   input job_type job,
   output logic rsp_strobe,
   output rsp_type rsp_word
);

   localparam int DIV_LAT = QUO_W + 1;

   mat_type mat_sel [4];
   logic signed [DET_W-1:0] det [4];
   logic valid_det_ff [DET_LAT];
   logic is2_det_ff [DET_LAT];
   logic [MAG_W-1:0] thr_det_ff [DET_LAT];

   logic [MAG_W-1:0] den_abs;
   logic [MAG_W-1:0] num_abs [3];
   logic [2:0] neg_in;
   logic ok_in;
   logic prep_valid_ff, ok_ff, is2_ff;
   logic [2:0] neg_ff;
   logic [MAG_W-1:0] den_ff;
   logic [MAG_W-1:0] num_ff [3];

   logic [QUO_W-1:0] quo [3];
   logic over [3];
   logic valid_div_ff [DIV_LAT];
   logic ok_div_ff [DIV_LAT];
   logic is2_div_ff [DIV_LAT];
   logic [2:0] neg_div_ff [DIV_LAT];

   logic [QUO_W-1:0] lim [3];
   logic [QUO_W-1:0] mag [3];
   logic [QUO_W-1:0] sol_val [3];
   logic [2:0] sat_vec;
   rsp_type rsp_in, rsp_ff;
   logic rsp_strobe_ff, is2_out_ff;

   // The matrix itself and the three with one column replaced by the right side.
   always_comb begin
      for (int u = 0; u < 4; u++) begin
         mat_sel[u] = job.mat;
         if (u != 0) begin
            for (int r = 0; r < 3; r++) begin
               mat_sel[u][r][u-1] = job.rhs[r];
            end
         end
      end
   end

   for (genvar u = 0; u < 4; u++) begin : g_det
      cramer_det u_det (
         .clock(clock),
         .mat(mat_sel[u]),
         .det(det[u])
      );
   end

   // Magnitudes, quotient signs and the singular test.
   always_comb begin
      den_abs = MAG_W'(det[0][DET_W-1] ? -det[0] : det[0]);
      ok_in = (det[0] != '0) && (den_abs >= thr_det_ff[DET_LAT-1]);
      for (int k = 0; k < 3; k++) begin
         num_abs[k] = MAG_W'(det[k+1][DET_W-1] ? -det[k+1] : det[k+1]);
         neg_in[k] = det[k+1][DET_W-1] ^ det[0][DET_W-1];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_div
      cramer_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock),
         .num_mag(num_ff[k]),
         .den_mag(den_ff),
         .quo(quo[k]),
         .over(over[k])
      );
   end

   // Clip, apply the sign and zero everything for a singular system.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lim[k] = neg_div_ff[DIV_LAT-1][k] ? SAT_NEG : SAT_POS;
         sat_vec[k] = over[k] || (quo[k] > lim[k]);
         mag[k] = sat_vec[k] ? lim[k] : quo[k];
         sol_val[k] = neg_div_ff[DIV_LAT-1][k] ? -mag[k] : mag[k];
      end
      rsp_in = '0;
      if (ok_div_ff[DIV_LAT-1]) begin
         rsp_in.sol_first = sol_val[0];
         rsp_in.sol_second = sol_val[1];
         rsp_in.sol_third = sol_val[2];
         rsp_in.solved = 1'b1;
         rsp_in.saturated = |sat_vec;
      end
   end

   // Control flags that travel beside the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DET_LAT; i++) begin
            valid_det_ff[i] <= 1'b0;
         end
         prep_valid_ff <= 1'b0;
         for (int i = 0; i < DIV_LAT; i++) begin
            valid_div_ff[i] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_det_ff[0] <= job_valid;
         for (int i = 1; i < DET_LAT; i++) begin
            valid_det_ff[i] <= valid_det_ff[i-1];
         end
         prep_valid_ff <= valid_det_ff[DET_LAT-1];
         valid_div_ff[0] <= prep_valid_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            valid_div_ff[i] <= valid_div_ff[i-1];
         end
         rsp_strobe_ff <= valid_div_ff[DIV_LAT-1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is2_det_ff[0] <= job.is_two;
      thr_det_ff[0] <= job.thr;
      for (int i = 1; i < DET_LAT; i++) begin
         is2_det_ff[i] <= is2_det_ff[i-1];
         thr_det_ff[i] <= thr_det_ff[i-1];
      end
      ok_ff <= ok_in;
      is2_ff <= is2_det_ff[DET_LAT-1];
      neg_ff <= neg_in;
      den_ff <= den_abs;
      for (int k = 0; k < 3; k++) begin
         num_ff[k] <= num_abs[k];
      end
      ok_div_ff[0] <= ok_ff;
      is2_div_ff[0] <= is2_ff;
      neg_div_ff[0] <= neg_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         ok_div_ff[i] <= ok_div_ff[i-1];
         is2_div_ff[i] <= is2_div_ff[i-1];
         neg_div_ff[i] <= neg_div_ff[i-1];
      end
      rsp_ff <= rsp_in;
      is2_out_ff <= is2_div_ff[DIV_LAT-1];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_ff;

   `CRM_ASSERT(a_singular_zero, (rsp_strobe_ff && !rsp_ff.solved) |-> (rsp_ff.sol_first == '0 && rsp_ff.sol_second == '0 && rsp_ff.sol_third == '0 && !rsp_ff.saturated))
   `CRM_ASSERT(a_sat_needs_solved, (rsp_strobe_ff && rsp_ff.saturated) |-> rsp_ff.solved)
   `CRM_ASSERT(a_two_third_zero, (rsp_strobe_ff && is2_out_ff) |-> (rsp_ff.sol_third == '0))
   `CRM_ASSERT_NEXT(a_det_to_prep, valid_det_ff[DET_LAT-1], prep_valid_ff)

endmodule

// ===== hw/rtl/cramer_linear_solve.sv =====
// Cramer's-rule solver for 2x2 and 3x3 systems in signed fixed point.
// rsp_strobe is high for one cycle; a word passes front, queue, determinants and divider.
// Throughput: one word per cycle unless busy; the 32-stage restoring divider sets latency.
// busy is the queue-full flag and stays low while the result side drains every cycle.
// Reset (synchronous, active high) empties the pipeline, sets threshold to 1 and size to 3.
module cramer_linear_solve import cramer_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_word,
   output logic rsp_strobe,
   output rsp_type rsp_word,
   input logic csr_wr_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [THR_W-1:0] csr_wdata
);

   logic req_take;
   logic job_valid;
   job_type job;
   job_type head_job;
   logic head_valid;
   logic full;

   assign req_take = start && !busy;
   assign busy = full;

   // Front: registers and classification of incoming words.
   cramer_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_take(req_take),
      .req_word(req_word),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .job_valid(job_valid),
      .job(job)
   );

   // Queue: the back takes its head whenever one is there.
   cramer_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_valid),
      .push_job(job),
      .pop(head_valid),
      .head_job(head_job),
      .head_valid(head_valid),
      .full(full)
   );

   // Back: determinants, singular test and quotients.
   cramer_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(head_valid),
      .job(head_job),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

endmodule

// ===== tb/sv/tb_cramer_linear_solve.sv =====
module tb_cramer_linear_solve;
   import cramer_pkg::*;

   localparam int FRAC = DEF_FRAC_BITS;
   localparam int LATENCY = 41;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 750;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_THRESHOLD;
   logic [THR_W-1:0] csr_wdata = '0;

   // Predictor copy of the two registers.
   logic [THR_W-1:0] thr_reg;
   logic [SIZE_W-1:0] size_reg;

   rsp_type solution_queue[$];
   int error_count = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   cramer_linear_solve u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exact determinant of a 2x2 or 3x3 matrix in wide signed arithmetic.
   function automatic logic signed [127:0] det_exact(input logic signed [127:0] m[3][3],
                                                     input bit two);
      if (two) return m[0][0] * m[1][1] - m[0][1] * m[1][0];
      return m[0][0] * (m[1][1] * m[2][2] - m[2][1] * m[1][2])
           - m[0][1] * (m[1][0] * m[2][2] - m[2][0] * m[1][2])
           + m[0][2] * (m[1][0] * m[2][1] - m[2][0] * m[1][1]);
   endfunction

   // Computes the expected solution of one system under the current registers.
   function automatic rsp_type solve_system(input req_type w);
      logic signed [127:0] a[3][3], work[3][3], rhs[3];
      logic signed [127:0] d, dk;
      logic [127:0] mag_d, mag_n, q, thr;
      logic [31:0] sols[3];
      logic [31:0] lim;
      bit two, neg, sat;
      rsp_type r;
      two = (size_reg == SIZE_TWO);
      sat = 0;
      sols = '{32'd0, 32'd0, 32'd0};
      a[0][0] = w.coef_r0_c0; a[0][1] = w.coef_r0_c1; a[0][2] = w.coef_r0_c2;
      a[1][0] = w.coef_r1_c0; a[1][1] = w.coef_r1_c1; a[1][2] = w.coef_r1_c2;
      a[2][0] = w.coef_r2_c0; a[2][1] = w.coef_r2_c1; a[2][2] = w.coef_r2_c2;
      rhs[0] = w.rhs_first; rhs[1] = w.rhs_second; rhs[2] = w.rhs_third;
      d = det_exact(a, two);
      mag_d = d < 0 ? -d : d;
      thr = 128'(thr_reg) << ((two ? 1 : 2) * FRAC);
      r = '0;
      if (d != 0 && mag_d >= thr) begin
         for (int k = 0; k < (two ? 2 : 3); k++) begin
            work = a;
            for (int i = 0; i < 3; i++) work[i][k] = rhs[i];
            dk = det_exact(work, two);
            neg = (dk < 0) != (d < 0);
            mag_n = dk < 0 ? -dk : dk;
            q = (mag_n << FRAC) / mag_d;
            lim = neg ? SAT_NEG : SAT_POS;
            if (q > 128'(lim)) begin
               q = 128'(lim);
               sat = 1;
            end
            sols[k] = neg ? -q[31:0] : q[31:0];
         end
         r.solved = 1'b1;
      end
      r.sol_first = sols[0];
      r.sol_second = sols[1];
      r.sol_third = sols[2];
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Result checker: every strobed word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_type e;
         if (solution_queue.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word.solved), 32'd0);
         end else begin
            e = solution_queue.pop_front();
            if (rsp_word.sol_first !== e.sol_first)
               report_mismatch("sol_first", rsp_word.sol_first, e.sol_first);
            if (rsp_word.sol_second !== e.sol_second)
               report_mismatch("sol_second", rsp_word.sol_second, e.sol_second);
            if (rsp_word.sol_third !== e.sol_third)
               report_mismatch("sol_third", rsp_word.sol_third, e.sol_third);
            if (rsp_word.solved !== e.solved)
               report_mismatch("solved", 32'(rsp_word.solved), 32'(e.solved));
            if (rsp_word.saturated !== e.saturated)
               report_mismatch("saturated", 32'(rsp_word.saturated), 32'(e.saturated));
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Presents one word and holds it until the block takes it. start stays high
   // afterwards so that words can follow back to back; idling drops it.
   task automatic send_word(input req_type w, input bit has_want, input rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      solution_queue.push_back(has_want ? want : solve_system(w));
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (solution_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_THRESHOLD) thr_reg = val;
      else if (idx == CSR_SIZE) size_reg = val[SIZE_W-1:0];
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coef(input int kind);
      case (kind)
         0: return $urandom;
         1: return 32'($signed($urandom_range(8, 0)) - 4) << FRAC;
         2: return 32'($signed($urandom_range(2000, 0)) - 1000) << 8;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic req_type random_system();
      req_type w;
      int kind;
      kind = $urandom_range(9);
      kind = kind < 1 ? 0 : (kind < 5 ? 1 : (kind < 9 ? 2 : 3));
      w.coef_r0_c0 = rand_coef(kind); w.coef_r0_c1 = rand_coef(kind);
      w.coef_r0_c2 = rand_coef(kind); w.coef_r1_c0 = rand_coef(kind);
      w.coef_r1_c1 = rand_coef(kind); w.coef_r1_c2 = rand_coef(kind);
      w.coef_r2_c0 = rand_coef(kind); w.coef_r2_c1 = rand_coef(kind);
      w.coef_r2_c2 = rand_coef(kind);
      w.rhs_first = rand_coef($urandom_range(3));
      w.rhs_second = rand_coef($urandom_range(3));
      w.rhs_third = rand_coef($urandom_range(3));
      // Occasionally make the matrix singular by repeating a row.
      if ($urandom_range(15) == 0) begin
         w.coef_r1_c0 = w.coef_r0_c0;
         w.coef_r1_c1 = w.coef_r0_c1;
         w.coef_r1_c2 = w.coef_r0_c2;
      end
      return w;
   endfunction

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   typedef struct {
      req_type w;
      bit has_want;
      rsp_type want;
   } stim_row;

   stim_row directed[$];

   initial begin
      rsp_type zero_rsp;
      rsp_type unit_rsp;
      int phase_pct[4];
      zero_rsp = '0;
      unit_rsp = '0;
      unit_rsp.sol_first = 32'sd2 <<< FRAC;
      unit_rsp.sol_second = 32'sd3 <<< FRAC;
      unit_rsp.sol_third = -(32'sd4 <<< FRAC);
      unit_rsp.solved = 1'b1;
      thr_reg = THR_RESET;
      size_reg = SIZE_RESET;

      // Identity, zero matrix, all-max and all-min words, plus checked mixed rows.
      directed.push_back('{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE,
                            2 << FRAC, 3 << FRAC, -(4 << FRAC)}, 1, unit_rsp});
      directed.push_back('{'0, 1, zero_rsp});
      directed.push_back('{'{12{MAXV}}, 1, zero_rsp});
      directed.push_back('{'{12{MINV}}, 1, zero_rsp});
      directed.push_back('{'{1, 0, 0, 0, 1, 0, 0, 0, 1, MAXV, MINV, MAXV}, 0, zero_rsp});
      directed.push_back('{'{MAXV, 0, 0, 0, MINV, 0, 0, 0, MAXV, MINV, MAXV, 1},
                           0, zero_rsp});
      directed.push_back('{'{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE, ONE, ONE, ONE},
                           0, zero_rsp});
      directed.push_back('{'{MINV, MAXV, 1, -1, MINV, 5, 7, 9, MAXV, -1, 1, MINV},
                           0, zero_rsp});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_word(directed[i].w, directed[i].has_want, directed[i].want);
      drain();

      // Two-by-two mode with a zero threshold, then the largest threshold.
      write_reg(CSR_SIZE, THR_W'(SIZE_TWO));
      write_reg(CSR_THRESHOLD, '0);
      foreach (directed[i]) send_word(directed[i].w, 0, zero_rsp);
      drain();
      write_reg(CSR_THRESHOLD, '1);
      for (int i = 0; i < 6; i++) send_word(random_system(), 0, zero_rsp);
      drain();
      // Unused size codes act as a full system; an index beyond the list is ignored.
      write_reg(CSR_SIZE, THR_W'(2'd0));
      write_reg(2'd3, '1);
      write_reg(CSR_THRESHOLD, THR_W'(ONE));
      for (int i = 0; i < 6; i++) send_word(random_system(), 0, zero_rsp);
      drain();
      write_reg(CSR_SIZE, THR_W'(2'd1));

      // Random phases with varied sender idling and register settings.
      phase_pct = '{0, 75, 0, 21};
      for (int p = 0; p < 8; p++) begin
         sender_idle_pct = phase_pct[p % 4];
         for (int i = 0; i < RANDOM_ITEMS / 8; i++) begin
            send_word(random_system(), 0, zero_rsp);
            if (i == 40 && p == 2) begin
               start <= 1'b0;
               while (solution_queue.size() != 0) @(negedge clock);
            end
         end
         drain();
         write_reg(CSR_SIZE, THR_W'($urandom_range(3)));
         case ($urandom_range(3))
            0: write_reg(CSR_THRESHOLD, '0);
            1: write_reg(CSR_THRESHOLD, THR_W'($urandom_range(16)));
            2: write_reg(CSR_THRESHOLD, THR_W'($urandom));
            default: write_reg(CSR_THRESHOLD, THR_W'(ONE));
         endcase
      end

      drain();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
